// ----- design/flsd_pkg.sv -----
// Shared types and constants for the frame level segment detector.
package flsd_pkg;

    localparam int unsigned TIME_BITS = 24;
    localparam int unsigned HOUR_BITS = 13;
    localparam int unsigned MS_BITS   = 6;
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE_ABOVE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MERGE_GAP  = 2'd2;

    localparam logic [15:0] THRESHOLD_RESET = 16'd1280;
    localparam logic [7:0]  MERGE_GAP_RESET = 8'd5;

    // s / 3600 == (s * HOUR_RECIP) >> HOUR_SHIFT, exact for 24-bit s
    localparam logic [23:0] HOUR_RECIP = 24'd9544372;
    localparam int unsigned HOUR_SHIFT = 35;
    localparam logic [23:0] SECS_PER_HOUR = 24'd3600;
    // r / 60 == (r * MIN_RECIP) >> MIN_SHIFT, exact for r < 3600
    localparam logic [11:0] MIN_RECIP = 12'd2185;
    localparam int unsigned MIN_SHIFT = 17;
    localparam logic [11:0] SECS_PER_MIN = 12'd60;

    localparam int unsigned Q_DEPTH = 8;
    localparam int unsigned Q_ADDR_BITS = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [TIME_BITS-1:0] frame_time_sec;
        logic [15:0]          mean_power;
        logic                 last_frame;
        logic [TIME_BITS-1:0] stream_end_sec;
    } in_t;

    typedef struct packed {
        logic [HOUR_BITS-1:0] start_hours;
        logic [MS_BITS-1:0]   start_minutes;
        logic [MS_BITS-1:0]   start_seconds;
        logic [HOUR_BITS-1:0] end_hours;
        logic [MS_BITS-1:0]   end_minutes;
        logic [MS_BITS-1:0]   end_seconds;
        logic                 run_last;
    } out_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] start_sec;
        logic [TIME_BITS-1:0] end_sec;
        logic                 run_last;
    } period_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   secs;
        logic [2*TIME_BITS-1:0] prod;
    } conv1_t;

    typedef struct packed {
        logic [HOUR_BITS-1:0] hours;
        logic [11:0]          rem;
    } conv2_t;

    typedef struct packed {
        logic [HOUR_BITS-1:0] hours;
        logic [11:0]          rem;
        logic [23:0]          mprod;
    } conv3_t;

endpackage

// ----- design/frame_level_segment_detector_unit.sv -----
// Frame level segment detector: cluster tracking, period queue, h/m/s split.
//
// Path: input register, cluster step into the period queue, c1, c2, c3, output register.
// Throughput: one input item per cycle while the queue holds at most 5 periods; results
// leave at one per cycle unless out_ready holds them, through an 8-entry period queue.
// Reset: asynchronous, active low; clears cluster state, queue and pipeline
// and loads threshold 1280, mode below, merge gap 5.
module frame_level_segment_detector_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [flsd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [flsd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  flsd_pkg::in_t                        in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output flsd_pkg::out_t                       out_data
);
    import flsd_pkg::*;

    logic [15:0] threshold_reg;
    logic        mode_above_reg;
    logic [7:0]  merge_gap_reg;

    logic                 have_previous_reg, have_previous_next;
    logic [TIME_BITS-1:0] previous_first_reg, previous_first_next;
    logic [TIME_BITS-1:0] current_first_reg, current_first_next;
    logic [TIME_BITS-1:0] current_last_reg, current_last_next;

    logic in_valid_reg;
    in_t  in_data_reg;
    logic room;
    logic step_fire;

    period_t              q_reg [Q_DEPTH];
    logic [Q_ADDR_BITS-1:0] head_reg, tail_reg;
    logic [Q_CNT_BITS-1:0]  count_reg;
    logic                 q_pop;

    period_t        cand [3];
    logic [2:0]     emit;
    logic [1:0]     slot [3];
    logic [1:0]     n_emit;

    logic   en;
    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    conv1_t c1_reg [2];
    conv2_t c2_reg [2];
    conv3_t c3_reg [2];
    logic   l1_reg, l2_reg, l3_reg;
    out_t   out_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            mode_above_reg <= 1'b0;
            merge_gap_reg  <= MERGE_GAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:  threshold_reg  <= cfg_data;
                REG_MODE_ABOVE: mode_above_reg <= cfg_data[0];
                REG_MERGE_GAP:  merge_gap_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    assign room      = (count_reg <= Q_CNT_BITS'(Q_DEPTH - 3));
    assign step_fire = in_valid_reg && room;
    assign in_ready  = !in_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
    end

    // ---------------- cluster step ----------------
    always_comb
    begin
        logic                 marked;
        logic [TIME_BITS-1:0] t, e, gap_a, gap_b;
        logic                 hp_a;
        logic [TIME_BITS-1:0] pf_a, cf_a, cl_a;
        logic                 hp_b;
        logic [TIME_BITS-1:0] pf_b, cl_b;

        t = in_data_reg.frame_time_sec;
        e = in_data_reg.stream_end_sec;
        marked = mode_above_reg ? (in_data_reg.mean_power > threshold_reg)
                                : (in_data_reg.mean_power < threshold_reg);

        emit = 3'b000;
        for (int k = 0; k < 3; k++)
            cand[k] = '0;

        // marked frame time
        hp_a = have_previous_reg;
        pf_a = previous_first_reg;
        cf_a = current_first_reg;
        cl_a = current_last_reg;
        gap_a = (t >= current_last_reg) ? (t - current_last_reg) : (current_last_reg - t);
        if (marked)
        begin
            if (gap_a <= TIME_BITS'(merge_gap_reg))
                cl_a = t;
            else
            begin
                emit[0] = have_previous_reg;
                cand[0].start_sec = previous_first_reg;
                cand[0].end_sec   = current_last_reg;
                hp_a = 1'b1;
                pf_a = current_first_reg;
                cf_a = t;
                cl_a = t;
            end
        end

        // stream end time, then final close
        hp_b = hp_a;
        pf_b = pf_a;
        cl_b = cl_a;
        gap_b = (e >= cl_a) ? (e - cl_a) : (cl_a - e);
        if (gap_b <= TIME_BITS'(merge_gap_reg))
            cl_b = e;
        else
        begin
            emit[1] = in_data_reg.last_frame && hp_a;
            cand[1].start_sec = pf_a;
            cand[1].end_sec   = cl_a;
            hp_b = 1'b1;
            pf_b = cf_a;
            cl_b = e;
        end
        emit[2] = in_data_reg.last_frame && hp_b;
        cand[2].start_sec = pf_b;
        cand[2].end_sec   = cl_b;

        cand[0].run_last = !emit[1] && !emit[2];
        cand[1].run_last = !emit[2];
        cand[2].run_last = 1'b1;

        slot[0] = 2'd0;
        slot[1] = {1'b0, emit[0]};
        slot[2] = {1'b0, emit[0]} + {1'b0, emit[1]};
        n_emit  = slot[2] + {1'b0, emit[2]};

        if (in_data_reg.last_frame)
        begin
            have_previous_next  = 1'b0;
            previous_first_next = '0;
            current_first_next  = '0;
            current_last_next   = '0;
        end
        else
        begin
            have_previous_next  = hp_a;
            previous_first_next = pf_a;
            current_first_next  = cf_a;
            current_last_next   = cl_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_previous_reg  <= 1'b0;
            previous_first_reg <= '0;
            current_first_reg  <= '0;
            current_last_reg   <= '0;
        end
        else if (step_fire)
        begin
            have_previous_reg  <= have_previous_next;
            previous_first_reg <= previous_first_next;
            current_first_reg  <= current_first_next;
            current_last_reg   <= current_last_next;
        end
    end

    // ---------------- period queue ----------------
    assign en    = !v4_reg || out_ready;
    assign q_pop = en && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (emit[k])
                    q_reg[tail_reg + Q_ADDR_BITS'(slot[k])] <= cand[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (step_fire)
                tail_reg <= tail_reg + Q_ADDR_BITS'(n_emit);
            if (q_pop)
                head_reg <= head_reg + Q_ADDR_BITS'(1);
            count_reg <= count_reg + (step_fire ? Q_CNT_BITS'(n_emit) : '0)
                         - Q_CNT_BITS'(q_pop);
        end
    end

    // ---------------- h/m/s split pipeline ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= q_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [TIME_BITS-1:0] s_in [2];
        logic [TIME_BITS-1:0] h_full;
        logic [HOUR_BITS-1:0] h;
        logic [MS_BITS-1:0]   m [2];
        logic [11:0]          sec [2];

        s_in[0] = q_reg[head_reg].start_sec;
        s_in[1] = q_reg[head_reg].end_sec;
        for (int k = 0; k < 2; k++)
        begin
            m[k]   = c3_reg[k].mprod[MIN_SHIFT +: MS_BITS];
            sec[k] = c3_reg[k].rem - 12'(m[k] * SECS_PER_MIN);
        end
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                c1_reg[k].secs <= s_in[k];
                c1_reg[k].prod <= {{TIME_BITS{1'b0}}, s_in[k]}
                                  * {{TIME_BITS{1'b0}}, HOUR_RECIP};
                h_full = TIME_BITS'(c1_reg[k].prod >> HOUR_SHIFT);
                h = h_full[HOUR_BITS-1:0];
                c2_reg[k].hours <= h;
                c2_reg[k].rem   <= 12'(c1_reg[k].secs - TIME_BITS'(h_full * SECS_PER_HOUR));
                c3_reg[k].hours <= c2_reg[k].hours;
                c3_reg[k].rem   <= c2_reg[k].rem;
                c3_reg[k].mprod <= {12'd0, c2_reg[k].rem} * {12'd0, MIN_RECIP};
            end
            l1_reg <= q_reg[head_reg].run_last;
            l2_reg <= l1_reg;
            l3_reg <= l2_reg;
            out_reg.start_hours   <= c3_reg[0].hours;
            out_reg.start_minutes <= m[0];
            out_reg.start_seconds <= sec[0][MS_BITS-1:0];
            out_reg.end_hours     <= c3_reg[1].hours;
            out_reg.end_minutes   <= m[1];
            out_reg.end_seconds   <= sec[1][MS_BITS-1:0];
            out_reg.run_last      <= l3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_BITS'(Q_DEPTH))
        else $error("period queue overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("pop from empty period queue");

    a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |-> count_reg <= Q_CNT_BITS'(Q_DEPTH - 3))
        else $error("step without queue room");

    a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && in_data_reg.last_frame |=>
            !have_previous_reg && current_last_reg == '0 && current_first_reg == '0)
        else $error("cluster state not cleared after stream end");

    a_hms_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.start_minutes < 6'd60 && out_data.start_seconds < 6'd60
                   && out_data.end_minutes < 6'd60 && out_data.end_seconds < 6'd60)
        else $error("minutes or seconds out of range");

endmodule

// ----- tb/flsd_period_checker.sv -----
// Checker for the frame level segment detector: predicts periods and compares transfers.
module flsd_period_checker
    import flsd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  in_t                      in_data,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  out_t                     out_data,
    output int                       errors,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOUR_SECS   = 3600;
    localparam int unsigned MINUTE_SECS = 60;

    logic [15:0]          threshold_q;
    logic                 mode_above_q;
    logic [7:0]           merge_gap_q;

    logic                 seen_cluster;
    logic [TIME_BITS-1:0] prior_first;
    logic [TIME_BITS-1:0] open_first;
    logic [TIME_BITS-1:0] open_last;

    out_t                 step_periods[3];
    int                   step_count;
    out_t                 expected_periods[$];

    int                   mismatches = 0;
    int                   outstanding = 0;

    assign errors  = mismatches;
    assign pending = outstanding;

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic out_t to_hms_period(logic [TIME_BITS-1:0] s, logic [TIME_BITS-1:0] e);
        out_t        p;
        int unsigned si;
        int unsigned ei;
        si = 32'(s);
        ei = 32'(e);
        p.start_hours   = HOUR_BITS'((si / HOUR_SECS) & 'h1FFF);
        p.start_minutes = MS_BITS'((si % HOUR_SECS) / MINUTE_SECS);
        p.start_seconds = MS_BITS'(si % MINUTE_SECS);
        p.end_hours     = HOUR_BITS'((ei / HOUR_SECS) & 'h1FFF);
        p.end_minutes   = MS_BITS'((ei % HOUR_SECS) / MINUTE_SECS);
        p.end_seconds   = MS_BITS'(ei % MINUTE_SECS);
        p.run_last      = 1'b0;
        return p;
    endfunction

    function automatic void clear_clusters();
        seen_cluster = 1'b0;
        prior_first  = '0;
        open_first   = '0;
        open_last    = '0;
    endfunction

    // a period needs a cluster before the one that closes
    function automatic void finish_cluster();
        if (seen_cluster)
        begin
            step_periods[step_count] = to_hms_period(prior_first, open_last);
            step_count++;
        end
        prior_first  = open_first;
        seen_cluster = 1'b1;
    endfunction

    function automatic void take_marked_time(logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] gap;
        gap = (t >= open_last) ? t - open_last : open_last - t;
        if (gap <= TIME_BITS'(merge_gap_q))
        begin
            open_last = t;
        end
        else
        begin
            finish_cluster();
            open_first = t;
            open_last  = t;
        end
    endfunction

    function automatic void predict_periods(in_t item);
        logic marked;
        marked = mode_above_q ? (item.mean_power > threshold_q)
                              : (item.mean_power < threshold_q);
        step_count = 0;
        if (marked)
            take_marked_time(item.frame_time_sec);
        if (item.last_frame)
        begin
            take_marked_time(item.stream_end_sec);
            finish_cluster();
            clear_clusters();
        end
        if (step_count > 0)
            step_periods[step_count-1].run_last = 1'b1;
        for (int k = 0; k < step_count; k++)
            expected_periods = {expected_periods, step_periods[k]};
    endfunction

    task automatic check_period(out_t got);
        out_t want;
        if (expected_periods.size() == 0)
        begin
            report_mismatch($sformatf("unexpected period transfer %h", got));
            return;
        end
        want = expected_periods.pop_front();
        compare_field("start_hours", 32'(got.start_hours), 32'(want.start_hours));
        compare_field("start_minutes", 32'(got.start_minutes), 32'(want.start_minutes));
        compare_field("start_seconds", 32'(got.start_seconds), 32'(want.start_seconds));
        compare_field("end_hours", 32'(got.end_hours), 32'(want.end_hours));
        compare_field("end_minutes", 32'(got.end_minutes), 32'(want.end_minutes));
        compare_field("end_seconds", 32'(got.end_seconds), 32'(want.end_seconds));
        compare_field("run_last", 32'(got.run_last), 32'(want.run_last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_q  = THRESHOLD_RESET;
            mode_above_q = 1'b0;
            merge_gap_q  = MERGE_GAP_RESET;
            clear_clusters();
            expected_periods.delete();
            outstanding  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_period(out_data);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_THRESHOLD:  threshold_q  = cfg_data;
                    REG_MODE_ABOVE: mode_above_q = cfg_data[0];
                    REG_MERGE_GAP:  merge_gap_q  = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_periods(in_data);
            outstanding = expected_periods.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top: clock, reset, frame stimulus, result sink, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import flsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int SQUEEZE_CYCLES = 120;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    in_t                      in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    out_t                     out_data;

    int errors;
    int pending;
    int quiet_cycles  = 0;
    bit burst_mode    = 1'b0;
    bit squeeze_req   = 1'b0;
    bit squeeze_done  = 1'b0;
    int cur_threshold = int'(THRESHOLD_RESET);
    bit cur_mode      = 1'b0;
    int cur_gap       = int'(MERGE_GAP_RESET);

    frame_level_segment_detector_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    flsd_period_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #2 clk = ~clk;

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic in_t make_frame(logic [TIME_BITS-1:0] t, logic [15:0] p, logic last,
                                       logic [TIME_BITS-1:0] stop);
        in_t f;
        f.frame_time_sec = t;
        f.mean_power     = p;
        f.last_frame     = last;
        f.stream_end_sec = stop;
        return f;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // grey level that marks or not under the current threshold and mode
    function automatic logic [15:0] level_for(bit want_mark);
        int thr;
        thr = cur_threshold;
        if (thr <= 65280 && $urandom_range(0, 9) == 0)
            return 16'(thr);
        if (!cur_mode)
        begin
            if (want_mark)
                return (thr == 0) ? 16'd0
                    : 16'($urandom_range(0, (thr - 1 > 65280) ? 65280 : thr - 1));
            return 16'($urandom_range((thr > 65280) ? 65280 : thr, 65280));
        end
        if (want_mark)
            return 16'($urandom_range((thr + 1 > 65280) ? 65280 : thr + 1, 65280));
        return 16'($urandom_range(0, (thr > 65280) ? 65280 : thr));
    endfunction

    task automatic send_frame(in_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] thr, logic mode, logic [7:0] gap);
        cur_threshold = int'(thr);
        cur_mode      = mode;
        cur_gap       = int'(gap);
        cfg_write <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_index <= REG_MODE_ABOVE;
        cfg_data  <= {15'd0, mode};
        @(posedge clk);
        cfg_index <= REG_MERGE_GAP;
        cfg_data  <= {8'd0, gap};
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_stream(int frames);
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] stop;
        int                   span;
        int                   r;
        span = cur_gap + 4;
        if ($urandom_range(0, 9) == 0)
            t = 24'hFFFFFF - TIME_BITS'($urandom_range(0, 400));
        else
            t = TIME_BITS'($urandom_range(0, 20000));
        for (int k = 0; k < frames; k++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                t = t - TIME_BITS'($urandom_range(0, span));
            else if (r < 3)
                t = t + TIME_BITS'($urandom_range(span, 4000));
            else
                t = t + TIME_BITS'($urandom_range(0, 2 * span));
            if (k == frames - 1)
                stop = ($urandom_range(0, 9) == 0) ? TIME_BITS'($urandom())
                       : t + TIME_BITS'($urandom_range(0, 2 * span));
            else
                stop = TIME_BITS'($urandom());
            send_frame(make_frame(t, level_for($urandom_range(0, 99) < 65), k == frames - 1,
                                  stop));
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                send_frame(make_frame(TIME_BITS'($urandom()), 16'($urandom_range(0, 65280)),
                                      1'($urandom_range(0, 1)), TIME_BITS'($urandom())));
                sent++;
            end
            else
            begin
                n = $urandom_range(2, 8);
                send_stream(n);
                sent += n;
            end
        end
    endtask

    // result sink with random stalls and one long hold-off
    initial
    begin
        int r;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                else if (r < 62)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
                else if (r < 92)
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(10, 30)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: threshold 1280, below, gap 5
        send_frame(make_frame(0, 0, 0, 0));
        send_frame(make_frame(3, 1280, 0, 24'hFFFFFF));
        send_frame(make_frame(100, 0, 0, 0));
        send_frame(make_frame(200, 65280, 1, 300));
        send_frame(make_frame(100, 0, 0, 0));
        send_frame(make_frame(200, 1279, 1, 300));
        send_frame(make_frame(50, 0, 0, 0));
        send_frame(make_frame(47, 0, 0, 0));
        send_frame(make_frame(10, 0, 0, 0));
        send_frame(make_frame(12, 2000, 1, 12));
        send_frame(make_frame(500, 0, 0, 0));
        send_frame(make_frame(500, 0, 0, 0));
        send_frame(make_frame(511, 0, 0, 0));
        send_frame(make_frame(511, 65280, 1, 506));
        send_frame(make_frame(24'hFFFFFF, 0, 1, 24'hFFFFFF));
        send_frame(make_frame(0, 65280, 1, 0));
        settle();

        set_config(16'hFFFF, 1'b0, 8'd0);
        send_frame(make_frame(7, 65280, 0, 0));
        send_frame(make_frame(7, 65280, 0, 0));
        send_frame(make_frame(8, 65280, 0, 0));
        send_frame(make_frame(8, 65280, 1, 8));
        settle();

        set_config(16'h0000, 1'b1, 8'd255);
        send_frame(make_frame(300, 0, 0, 0));
        send_frame(make_frame(300, 1, 0, 0));
        send_frame(make_frame(555, 65280, 0, 0));
        send_frame(make_frame(811, 65280, 0, 0));
        send_frame(make_frame(811, 0, 1, 24'hFFFFFF));
        settle();

        // input backs up while the sink holds off
        set_config(16'd1280, 1'b0, 8'd2);
        burst_mode  = 1'b1;
        squeeze_req = 1'b1;
        wait (squeeze_done);
        random_phase(20);
        burst_mode  = 1'b0;
        random_phase(10);
        settle();

        set_config(16'($urandom_range(0, 65535)), 1'b1, 8'($urandom_range(0, 30)));
        random_phase(14);
        settle();

        set_config(16'hFFFF, 1'b0, 8'd255);
        random_phase(14);
        settle();

        set_config(16'h0000, 1'b1, 8'd0);
        random_phase(14);
        settle();

        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
